/* hdl/pafk_pkg.sv */
// shared types and constants of the planar arm forward kinematics block
package pafk_pkg;

  localparam int unsigned NumLinksDefault = 6;
  localparam int unsigned LinkSlots       = 6;
  localparam int unsigned AngleW          = 16;
  localparam int unsigned LenW            = 16;
  localparam int unsigned BaseW           = 24;
  localparam int unsigned PosW            = 28;
  localparam int unsigned IdxW            = 3;
  localparam int unsigned CntW            = 3;
  localparam int unsigned CfgIdxW         = 4;
  localparam int unsigned CfgDataW        = 24;

  // serial multiplier operand width and signed product width
  localparam int unsigned MulW  = 17;
  localparam int unsigned ProdW = 2 * MulW + 1;
  localparam int unsigned Q14   = 14;
  localparam int unsigned Q16   = 16;
  localparam int unsigned HalfShift = 15;
  localparam int unsigned FullShift = 14;

  // polynomial sine coefficients, Q16
  localparam logic [MulW-1:0] SinA = 17'd102944;
  localparam logic [MulW-1:0] SinB = 17'd42047;
  localparam logic [MulW-1:0] SinC = 17'd4640;
  localparam logic [MulW-1:0] QuarterZ = 17'd16384;
  localparam logic [AngleW-1:0] QuarterTurn = 16'h4000;
  localparam logic [LenW-1:0] LengthReset = 16'd256;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_X   = 4'd0,
    CFG_BASE_Y   = 4'd1,
    CFG_LENGTH_0 = 4'd2,
    CFG_LENGTH_1 = 4'd3,
    CFG_LENGTH_2 = 4'd4,
    CFG_LENGTH_3 = 4'd5,
    CFG_LENGTH_4 = 4'd6,
    CFG_LENGTH_5 = 4'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    LS_IDLE,
    LS_ZSQ,
    LS_TC,
    LS_TU,
    LS_SU,
    LS_LEN
  } lane_state_e;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_START,
    TS_CALC,
    TS_EMIT
  } top_state_e;

  typedef struct packed {
    logic            start;
    logic [MulW-1:0] a;
    logic [MulW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [2*MulW-1:0] p;
  } mul_rsp_t;

endpackage

/* hdl/pafk_smul.sv */
// bit-serial shift-add multiplier, one multiplier bit per cycle
module pafk_smul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pafk_pkg::mul_req_t req_i,
  output pafk_pkg::mul_rsp_t rsp_o
);
  import pafk_pkg::*;

  localparam int unsigned StepW = $clog2(MulW + 1);

  logic [MulW-1:0]   a_q;
  logic [2*MulW-1:0] p_q, p_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              done_q, done_d;
  logic [MulW:0]     sum;

  always_comb begin
    sum    = {1'b0, p_q[2*MulW-1:MulW]} + (p_q[0] ? {1'b0, a_q} : {(MulW+1){1'b0}});
    p_d    = p_q;
    step_d = step_q;
    done_d = 1'b0;
    if (req_i.start) begin
      p_d    = {{MulW{1'b0}}, req_i.b};
      step_d = StepW'(MulW);
    end else if (step_q != '0) begin
      p_d    = {sum, p_q[MulW-1:1]};
      step_d = step_q - 1'b1;
      done_d = (step_q == StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (req_i.start) begin
      a_q <= req_i.a;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = p_q;

endmodule

/* hdl/pafk_lane.sv */
// one trig lane: polynomial sine of a binary angle scaled by a link length
module pafk_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [pafk_pkg::AngleW-1:0]           angle_i,
  input  logic [pafk_pkg::LenW-1:0]             length_i,
  output logic                                  done_o,
  output logic signed [pafk_pkg::ProdW-1:0]     prod_o
);
  import pafk_pkg::*;

  lane_state_e     state_q, state_d;
  mul_req_t        req;
  mul_rsp_t        rsp;
  logic            neg_q;
  logic [MulW-1:0] z_q, z2_q;
  logic [LenW-1:0] len_q;
  logic [MulW-1:0] z_c, z2_c, t_c, u_c, s_c;
  logic [ProdW-1:0] mag;

  pafk_smul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // quadrant fold
  always_comb begin
    if (angle_i[Q14]) begin
      z_c = QuarterZ - MulW'(angle_i[Q14-1:0]);
    end else begin
      z_c = MulW'(angle_i[Q14-1:0]);
    end
    z2_c = rsp.p[Q14+MulW-1:Q14];
    t_c  = SinB - rsp.p[Q14+MulW-1:Q14];
    u_c  = SinA - rsp.p[Q14+MulW-1:Q14];
    s_c  = rsp.p[Q16+MulW-1:Q16];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LS_IDLE: if (start_i)  state_d = LS_ZSQ;
      LS_ZSQ:  if (rsp.done) state_d = LS_TC;
      LS_TC:   if (rsp.done) state_d = LS_TU;
      LS_TU:   if (rsp.done) state_d = LS_SU;
      LS_SU:   if (rsp.done) state_d = LS_LEN;
      LS_LEN:  if (rsp.done) state_d = LS_IDLE;
      default: state_d = LS_IDLE;
    endcase
  end

  always_comb begin
    req.start = 1'b0;
    req.a     = z_q;
    req.b     = z_q;
    done_o    = 1'b0;
    unique case (state_q)
      LS_IDLE: begin
        req.start = start_i;
        req.a     = z_c;
        req.b     = z_c;
      end
      LS_ZSQ: begin
        req.start = rsp.done;
        req.a     = z2_c;
        req.b     = SinC;
      end
      LS_TC: begin
        req.start = rsp.done;
        req.a     = z2_q;
        req.b     = t_c;
      end
      LS_TU: begin
        req.start = rsp.done;
        req.a     = z_q;
        req.b     = u_c;
      end
      LS_SU: begin
        req.start = rsp.done;
        req.a     = MulW'(len_q);
        req.b     = s_c;
      end
      LS_LEN: begin
        done_o = rsp.done;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == LS_IDLE && start_i) begin
      neg_q <= angle_i[AngleW-1];
      z_q   <= z_c;
      len_q <= length_i;
    end
    if (state_q == LS_ZSQ && rsp.done) begin
      z2_q <= z2_c;
    end
  end

  assign mag    = {1'b0, rsp.p};
  assign prod_o = neg_q ? $signed(~mag + 1'b1) : $signed(mag);

endmodule

/* hdl/planar_arm_forward_kinematics_top.sv */
// top level: pose sequencer, joint accumulators and result register
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------
//  in      | in_valid_i  / in_ready_o  | angle_0_i..angle_5_i, angle_count_i
//  out     | out_valid_o / out_ready_i | link_index_o, center_x_o, center_y_o,
//          |                           | absolute_angle_o, last_link_o
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// a pose is computed one link after another, each link taking five bit-serial
// multiplies in each of the cos and sin lanes
// one pose is in flight at a time; in_ready_o is high only between poses
// the result register lets the last link wait while the next pose is taken
// a stalled result holds the sequencer; reset returns it to idle
module planar_arm_forward_kinematics_top #(
  parameter int unsigned NumLinks = pafk_pkg::NumLinksDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pafk_pkg::AngleW-1:0]     angle_0_i,
  input  logic [pafk_pkg::AngleW-1:0]     angle_1_i,
  input  logic [pafk_pkg::AngleW-1:0]     angle_2_i,
  input  logic [pafk_pkg::AngleW-1:0]     angle_3_i,
  input  logic [pafk_pkg::AngleW-1:0]     angle_4_i,
  input  logic [pafk_pkg::AngleW-1:0]     angle_5_i,
  input  logic [pafk_pkg::CntW-1:0]       angle_count_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pafk_pkg::IdxW-1:0]       link_index_o,
  output logic signed [pafk_pkg::PosW-1:0] center_x_o,
  output logic signed [pafk_pkg::PosW-1:0] center_y_o,
  output logic signed [pafk_pkg::AngleW-1:0] absolute_angle_o,
  output logic                            last_link_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pafk_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pafk_pkg::CfgDataW-1:0]   cfg_data_i
);
  import pafk_pkg::*;

  top_state_e state_q, state_d;

  logic signed [BaseW-1:0] base_x_q, base_y_q;
  logic [LenW-1:0]         length_q [LinkSlots];
  logic [AngleW-1:0]       angle_q [LinkSlots];
  logic [CntW-1:0]         count_q;
  logic [IdxW-1:0]         link_q;
  logic [AngleW-1:0]       cum_q, cum_c;
  logic signed [PosW-1:0]  jx_q, jy_q;

  logic                    out_valid_q;
  logic [IdxW-1:0]         out_idx_q;
  logic signed [PosW-1:0]  out_x_q, out_y_q;
  logic [AngleW-1:0]       out_ang_q;
  logic                    out_last_q;

  logic                    lane_start, cos_done, sin_done;
  logic signed [ProdW-1:0] cos_prod, sin_prod;
  logic signed [PosW-1:0]  half_x, half_y, full_x, full_y;
  logic                    in_fire, cfg_fire, out_free, last_c, emit;
  cfg_idx_e                cfg_idx;

  assign in_fire  = in_valid_i && in_ready_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign last_c   = (link_q == IdxW'(NumLinks - 1));
  assign emit     = (state_q == TS_EMIT) && out_free;
  assign cfg_idx  = cfg_idx_e'(cfg_index_i);

  assign cum_c = (link_q < count_q) ? cum_q + angle_q[link_q] : cum_q;
  assign lane_start = (state_q == TS_START);

  pafk_lane u_cos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lane_start),
    .angle_i  (cum_c + QuarterTurn),
    .length_i (length_q[link_q]),
    .done_o   (cos_done),
    .prod_o   (cos_prod)
  );

  pafk_lane u_sin (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lane_start),
    .angle_i  (cum_c),
    .length_i (length_q[link_q]),
    .done_o   (sin_done),
    .prod_o   (sin_prod)
  );

  // floor shifts of the signed products
  always_comb begin
    half_x = PosW'($signed(cos_prod[ProdW-1:HalfShift]));
    half_y = PosW'($signed(sin_prod[ProdW-1:HalfShift]));
    full_x = PosW'($signed(cos_prod[ProdW-1:FullShift]));
    full_y = PosW'($signed(sin_prod[ProdW-1:FullShift]));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TS_IDLE:  if (in_valid_i) state_d = TS_START;
      TS_START: state_d = TS_CALC;
      TS_CALC:  if (cos_done && sin_done) state_d = TS_EMIT;
      TS_EMIT: begin
        if (out_free) begin
          state_d = last_c ? TS_IDLE : TS_START;
        end
      end
      default: state_d = TS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b1;
    unique case (state_q)
      TS_IDLE:  in_ready_o = 1'b1;
      TS_START: in_ready_o = 1'b0;
      TS_CALC:  in_ready_o = 1'b0;
      TS_EMIT:  in_ready_o = 1'b0;
      default:  in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TS_IDLE;
      link_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        link_q <= '0;
      end else if (emit) begin
        link_q <= link_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q <= '0;
      base_y_q <= '0;
      for (int i = 0; i < LinkSlots; i++) begin
        length_q[i] <= LengthReset;
      end
    end else if (cfg_fire) begin
      unique case (cfg_idx)
        CFG_BASE_X:   base_x_q    <= cfg_data_i;
        CFG_BASE_Y:   base_y_q    <= cfg_data_i;
        CFG_LENGTH_0: length_q[0] <= cfg_data_i[LenW-1:0];
        CFG_LENGTH_1: length_q[1] <= cfg_data_i[LenW-1:0];
        CFG_LENGTH_2: length_q[2] <= cfg_data_i[LenW-1:0];
        CFG_LENGTH_3: length_q[3] <= cfg_data_i[LenW-1:0];
        CFG_LENGTH_4: length_q[4] <= cfg_data_i[LenW-1:0];
        CFG_LENGTH_5: length_q[5] <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      angle_q[0] <= angle_0_i;
      angle_q[1] <= angle_1_i;
      angle_q[2] <= angle_2_i;
      angle_q[3] <= angle_3_i;
      angle_q[4] <= angle_4_i;
      angle_q[5] <= angle_5_i;
      count_q    <= angle_count_i;
      cum_q      <= '0;
      jx_q       <= PosW'(base_x_q);
      jy_q       <= PosW'(base_y_q);
    end
    if (state_q == TS_START) begin
      cum_q <= cum_c;
    end
    if (emit) begin
      out_idx_q  <= link_q;
      out_x_q    <= jx_q + half_x;
      out_y_q    <= jy_q + half_y;
      out_ang_q  <= cum_q;
      out_last_q <= last_c;
      jx_q       <= jx_q + full_x;
      jy_q       <= jy_q + full_y;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign link_index_o     = out_idx_q;
  assign center_x_o       = out_x_q;
  assign center_y_o       = out_y_q;
  assign absolute_angle_o = out_ang_q;
  assign last_link_o      = out_last_q;

endmodule

/* hdl/pafk_checker.sv */
// port-level checks of the top level, bound to it
module pafk_checker #(
  parameter int unsigned NumLinks = pafk_pkg::NumLinksDefault
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [pafk_pkg::IdxW-1:0]         link_index_o,
  input logic signed [pafk_pkg::PosW-1:0]  center_x_o,
  input logic                              last_link_o
);
  import pafk_pkg::*;

  logic out_stall;
  assign out_stall = out_valid_o && !out_ready_i;

  // result held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> out_valid_o && $stable(center_x_o) && $stable(link_index_o))
    else $error("result changed while stalled");

  // one pose at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second pose taken during a pose");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (link_index_o < IdxW'(NumLinks)))
    else $error("link index out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_link_o == (link_index_o == IdxW'(NumLinks - 1))))
    else $error("last link flag wrong");

  // a new result follows a link accepted before it in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_link_o) |=>
      (!out_valid_o || (link_index_o == $past(link_index_o) + 1'b1)))
    else $error("links out of order");

endmodule

bind planar_arm_forward_kinematics_top pafk_checker #(.NumLinks(NumLinks)) u_pafk_checker (.*);
